// File: src/mrg_jump_pkg.sv
// Package: types and constants for the order-3 MRG jump core.
`timescale 1ns / 1ps
package mrg_jump_pkg;
	localparam int unsigned WORD_W = 31;
	localparam logic [WORD_W-1:0] PRIME_MODULUS_DEF = 31'd2147483647;
	localparam logic [WORD_W-1:0] COEF_ONE_RST = 31'd2021422057;
	localparam logic [WORD_W-1:0] COEF_TWO_RST = 31'd1826992351;
	localparam logic [WORD_W-1:0] COEF_THREE_RST = 31'd1977753457;
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_ONE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_TWO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_THREE = 2'd2;

	typedef enum logic [1:0] {
		KIND_JUMP = 2'd0,
		KIND_BACK = 2'd1,
		KIND_LOAD = 2'd2,
		KIND_SEED = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [63:0] distance;
		logic signed [31:0] seed_word_a;
		logic signed [31:0] seed_word_b;
		logic signed [31:0] seed_word_c;
	} cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0] newest_word;
		logic [WORD_W-1:0] middle_word;
		logic [WORD_W-1:0] oldest_word;
	} result_t;
endpackage

// File: src/multiple_recursive_gen_jump_core.sv
// Order-3 multiple recursive generator with jump-ahead, backward step and seeding.
//
// One transaction per start pulse taken while busy is low; busy stays high until the
// result, which is shown for one cycle with done high and cannot be stalled. A new start
// is taken in the cycle that done is high. The modulus is the package constant and must
// be prime. All modular arithmetic runs through one bit-serial multiply/reduce unit (one
// multiplier bit per cycle) plus a bit-serial reducer for raw inputs (one bit per cycle,
// with a negative word negated first). A backward step takes up to 64 products, set by
// the Fermat inverse; a jump of distance d takes 27 products per bit of d up to its top
// set bit for the squaring, 27 more per set bit, and 9 for the final vector.
`timescale 1ns / 1ps
module multiple_recursive_gen_jump_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  mrg_jump_pkg::cmd_t          cmd,
	output logic                        done,
	output mrg_jump_pkg::result_t       result,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [30:0]                 cfg_data
);
	localparam int unsigned W = mrg_jump_pkg::WORD_W;
	localparam logic [W-1:0] PRIME_MODULUS = mrg_jump_pkg::PRIME_MODULUS_DEF;

	typedef enum logic [4:0] {
		S_IDLE, S_RED, S_RED_NEXT, S_SEED_FIX,
		S_JBIT, S_JMUL, S_JMUL_ACC, S_JSQ, S_JSQ_ACC, S_JVEC, S_JVEC_ACC,
		S_B_PROD, S_B_PROD_ACC, S_INV, S_INV_ACC, S_B_FIN, S_B_FIN_ACC, S_DONE
	} state_t;

	// serial modular multiplier: acc = acc*2 + b*bit (mod m), MSB first
	logic [W-1:0] mul_a_q, mul_b_q, mul_p_q;
	logic [5:0]   mul_cnt_q;
	logic         mul_busy_q;
	logic         mul_go;
	logic [W-1:0] mul_x, mul_y;

	function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y);
		logic [W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, PRIME_MODULUS}) s = s - {1'b0, PRIME_MODULUS};
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] subm(input logic [W-1:0] x, input logic [W-1:0] y);
		logic [W:0] s;
		if (x >= y) s = {1'b0, x} - {1'b0, y};
		else s = {1'b0, x} + {1'b0, PRIME_MODULUS} - {1'b0, y};
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] redm(input logic [W-1:0] x);
		return (x >= PRIME_MODULUS) ? x - PRIME_MODULUS : x;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_cnt_q <= '0;
		end else if (mul_go) begin
			mul_a_q <= mul_x;
			mul_b_q <= mul_y;
			mul_p_q <= '0;
			mul_cnt_q <= 6'(W);
			mul_busy_q <= 1'b1;
		end else if (mul_busy_q) begin
			mul_p_q <= addm(addm(mul_p_q, mul_p_q), mul_a_q[W-1] ? mul_b_q : '0);
			mul_a_q <= {mul_a_q[W-2:0], 1'b0};
			mul_cnt_q <= mul_cnt_q - 6'd1;
			if (mul_cnt_q == 6'd1) mul_busy_q <= 1'b0;
		end
	end

	state_t       st_q;
	logic [W-1:0] c_q [3];
	logic [W-1:0] sv_q [3];
	logic [W-1:0] acc_q [9];
	logic [W-1:0] base_q [9];
	logic [W-1:0] tmp_q [9];
	logic [63:0]  dist_q;
	logic [1:0]   row_q, col_q;
	logic [1:0]   k_q;
	logic [W-1:0] sum_q;
	logic [W-1:0] t_q, inv_q, invb_q;
	logic [4:0]   e_q;
	logic [1:0]   bsel_q, bstep_q;
	// serial reducer of 64-bit value, MSB first
	logic [63:0]  red_sh_q;
	logic [6:0]   red_cnt_q;
	logic [W-1:0] red_r_q;
	logic         red_neg_q;
	logic [1:0]   red_idx_q;
	logic [1:0]   kind_q;
	logic signed [31:0] sw_q [3];
	logic         mul_started_q;

	assign busy = (st_q != S_IDLE);

	// exponent m-2, bit e
	logic [W-1:0] exp_m2;
	assign exp_m2 = PRIME_MODULUS - 31'd2;

	// matrix element indexes: row*3+k, k*3+col, row*3+col
	logic [3:0] lhs_idx, rhs_idx, tmp_idx;
	assign lhs_idx = {2'b00, row_q} + {1'b0, row_q, 1'b0} + {2'b00, k_q};
	assign rhs_idx = {2'b00, k_q} + {1'b0, k_q, 1'b0} + {2'b00, col_q};
	assign tmp_idx = {2'b00, row_q} + {1'b0, row_q, 1'b0} + {2'b00, col_q};

	// backward product operand: sv[j+3-bsel] for coefficient j
	logic [1:0] bprod_idx;
	assign bprod_idx = bstep_q + 2'd3 - bsel_q;

	// highest nonzero coefficient, 3 when all are zero
	logic [1:0] bsel_d;
	always_comb begin
		if (redm(c_q[2]) != '0) bsel_d = 2'd2;
		else if (redm(c_q[1]) != '0) bsel_d = 2'd1;
		else if (redm(c_q[0]) != '0) bsel_d = 2'd0;
		else bsel_d = 2'd3;
	end

	always_comb begin
		mul_go = 1'b0;
		mul_x = '0;
		mul_y = '0;
		case (st_q)
			S_JMUL: begin
				mul_go = !mul_started_q;
				mul_x = acc_q[lhs_idx];
				mul_y = base_q[rhs_idx];
			end
			S_JSQ: begin
				mul_go = !mul_started_q;
				mul_x = base_q[lhs_idx];
				mul_y = base_q[rhs_idx];
			end
			S_JVEC: begin
				mul_go = !mul_started_q;
				mul_x = acc_q[lhs_idx];
				mul_y = sv_q[k_q];
			end
			S_B_PROD: begin
				mul_go = !mul_started_q;
				mul_x = c_q[bstep_q];
				mul_y = sv_q[bprod_idx];
			end
			S_INV: begin
				mul_go = !mul_started_q;
				mul_x = k_q[0] ? inv_q : invb_q;
				mul_y = invb_q;
			end
			S_B_FIN: begin
				mul_go = !mul_started_q;
				mul_x = t_q;
				mul_y = inv_q;
			end
			default: ;
		endcase
	end

	logic [W-1:0] red_src_next;
	always_comb begin
		red_src_next = addm(red_r_q, red_r_q);
		if (red_sh_q[63]) red_src_next = addm(red_src_next, 31'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
			c_q[0] <= mrg_jump_pkg::COEF_ONE_RST;
			c_q[1] <= mrg_jump_pkg::COEF_TWO_RST;
			c_q[2] <= mrg_jump_pkg::COEF_THREE_RST;
			sv_q[0] <= '0;
			sv_q[1] <= 31'd1;
			sv_q[2] <= 31'd1;
			mul_started_q <= 1'b0;
			e_q <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					mrg_jump_pkg::CFG_COEF_ONE:   c_q[0] <= cfg_data;
					mrg_jump_pkg::CFG_COEF_TWO:   c_q[1] <= cfg_data;
					mrg_jump_pkg::CFG_COEF_THREE: c_q[2] <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				S_IDLE: if (start) begin
					kind_q <= cmd.kind;
					dist_q <= cmd.distance;
					sw_q[0] <= cmd.seed_word_a;
					sw_q[1] <= cmd.seed_word_b;
					sw_q[2] <= cmd.seed_word_c;
					red_idx_q <= '0;
					mul_started_q <= 1'b0;
					case (mrg_jump_pkg::kind_t'(cmd.kind))
						mrg_jump_pkg::KIND_JUMP: begin
							for (int n = 0; n < 9; n++) acc_q[n] <= (n % 4 == 0) ? 31'd1 : '0;
							base_q[0] <= redm(c_q[0]);
							base_q[1] <= redm(c_q[1]);
							base_q[2] <= redm(c_q[2]);
							base_q[3] <= 31'd1; base_q[4] <= '0; base_q[5] <= '0;
							base_q[6] <= '0; base_q[7] <= 31'd1; base_q[8] <= '0;
							st_q <= S_JBIT;
						end
						mrg_jump_pkg::KIND_BACK: begin
							bsel_q <= bsel_d;
							bstep_q <= '0;
							t_q <= '0;
							st_q <= (bsel_d inside {2'd1, 2'd2}) ? S_B_PROD : S_B_FIN_ACC;
						end
						mrg_jump_pkg::KIND_LOAD: begin
							red_sh_q <= {{32{cmd.seed_word_a[31]}}, cmd.seed_word_a};
							red_neg_q <= cmd.seed_word_a[31];
							red_r_q <= '0;
							red_cnt_q <= 7'd64;
							t_q <= '0;
							st_q <= S_RED;
						end
						default: begin
							red_sh_q <= cmd.distance;
							red_neg_q <= cmd.distance[63];
							red_r_q <= '0;
							red_cnt_q <= 7'd64;
							t_q <= '0;
							st_q <= S_RED;
						end
					endcase
				end
				// reduce magnitude one bit per cycle; t_q flags a negative word
				S_RED: begin
					if (red_cnt_q == 7'd64 && red_neg_q) begin
						red_sh_q <= ~red_sh_q + 64'd1;
						red_neg_q <= 1'b0;
						red_cnt_q <= 7'd65;
						t_q <= 31'd1;
					end else if (red_cnt_q == 7'd65) begin
						red_cnt_q <= 7'd64;
					end else begin
						red_r_q <= red_src_next;
						red_sh_q <= {red_sh_q[62:0], 1'b0};
						red_cnt_q <= red_cnt_q - 7'd1;
						if (red_cnt_q == 7'd1) st_q <= S_RED_NEXT;
					end
				end
				S_RED_NEXT: begin
					t_q <= '0;
					if (kind_q == mrg_jump_pkg::KIND_SEED) begin
						sv_q[0] <= (t_q == 31'd1) ? subm('0, red_r_q) : red_r_q;
						sv_q[1] <= 31'd1;
						sv_q[2] <= 31'd1;
						st_q <= S_DONE;
					end else begin
						sv_q[red_idx_q] <= (t_q == 31'd1) ? subm('0, red_r_q) : red_r_q;
						if (red_idx_q == 2'd2) begin
							st_q <= S_DONE;
						end else begin
							red_idx_q <= red_idx_q + 2'd1;
							red_sh_q <= {{32{sw_q[red_idx_q + 2'd1][31]}},
								sw_q[red_idx_q + 2'd1]};
							red_neg_q <= sw_q[red_idx_q + 2'd1][31];
							red_r_q <= '0;
							red_cnt_q <= 7'd64;
							st_q <= S_RED;
						end
					end
				end
				S_SEED_FIX: st_q <= S_DONE;
				// jump: scan distance bits LSB first
				S_JBIT: begin
					row_q <= '0; col_q <= '0; k_q <= '0; sum_q <= '0; mul_started_q <= 1'b0;
					if (dist_q == '0) st_q <= S_JVEC;
					else if (dist_q[0]) st_q <= S_JMUL;
					else st_q <= S_JSQ;
				end
				S_JMUL, S_JSQ, S_JVEC, S_B_PROD, S_INV, S_B_FIN: begin
					mul_started_q <= 1'b1;
					if (mul_started_q && !mul_busy_q) begin
						mul_started_q <= 1'b0;
						case (st_q)
							S_JMUL: st_q <= S_JMUL_ACC;
							S_JSQ: st_q <= S_JSQ_ACC;
							S_JVEC: st_q <= S_JVEC_ACC;
							S_B_PROD: st_q <= S_B_PROD_ACC;
							S_INV: st_q <= S_INV_ACC;
							default: st_q <= S_B_FIN_ACC;
						endcase
					end
				end
				S_JMUL_ACC, S_JSQ_ACC, S_JVEC_ACC: begin
					if (k_q == 2'd2) begin
						k_q <= '0;
						sum_q <= '0;
						tmp_q[tmp_idx] <= addm(sum_q, mul_p_q);
						if (row_q == 2'd2 && (st_q == S_JVEC_ACC || col_q == 2'd2)) begin
							row_q <= '0;
							col_q <= '0;
							case (st_q)
								S_JMUL_ACC: begin
									for (int n = 0; n < 8; n++) acc_q[n] <= tmp_q[n];
									acc_q[8] <= addm(sum_q, mul_p_q);
									st_q <= S_JSQ;
								end
								S_JSQ_ACC: begin
									for (int n = 0; n < 8; n++) base_q[n] <= tmp_q[n];
									base_q[8] <= addm(sum_q, mul_p_q);
									dist_q <= {1'b0, dist_q[63:1]};
									st_q <= S_JBIT;
								end
								default: begin
									// vector rows land at row*3
									sv_q[0] <= tmp_q[0];
									sv_q[1] <= tmp_q[3];
									sv_q[2] <= addm(sum_q, mul_p_q);
									st_q <= S_DONE;
								end
							endcase
						end else begin
							if (st_q == S_JVEC_ACC || col_q == 2'd2) begin
								row_q <= row_q + 2'd1;
								col_q <= '0;
							end else begin
								col_q <= col_q + 2'd1;
							end
							st_q <= (st_q == S_JMUL_ACC) ? S_JMUL :
							        (st_q == S_JSQ_ACC) ? S_JSQ : S_JVEC;
						end
					end else begin
						k_q <= k_q + 2'd1;
						sum_q <= addm(sum_q, mul_p_q);
						st_q <= (st_q == S_JMUL_ACC) ? S_JMUL :
						        (st_q == S_JSQ_ACC) ? S_JSQ : S_JVEC;
					end
				end
				// backward: t = sum of c[j]*sv[j+3-bsel] for j below bsel
				S_B_PROD_ACC: begin
					t_q <= addm(t_q, mul_p_q);
					if (bstep_q + 2'd1 >= bsel_q) st_q <= S_B_FIN_ACC;
					else begin
						bstep_q <= bstep_q + 2'd1;
						st_q <= S_B_PROD;
					end
				end
				S_INV_ACC: begin
					if (k_q[0]) begin
						inv_q <= mul_p_q;
						k_q <= 2'd0;
						st_q <= S_INV;
					end else begin
						invb_q <= mul_p_q;
						if (e_q == 5'd30) st_q <= S_B_FIN;
						else begin
							e_q <= e_q + 5'd1;
							k_q <= {1'b0, exp_m2[e_q + 5'd1]};
							st_q <= S_INV;
						end
					end
				end
				S_B_FIN_ACC: begin
					if (bsel_q == 2'd3) begin
						sv_q[0] <= sv_q[1]; sv_q[1] <= sv_q[2]; sv_q[2] <= '0;
						st_q <= S_DONE;
					end else if (e_q == 5'd31) begin
						sv_q[0] <= sv_q[1]; sv_q[1] <= sv_q[2]; sv_q[2] <= mul_p_q;
						st_q <= S_DONE;
					end else begin
						// t = sv[bsel_idx] - sum of products
						t_q <= subm(sv_q[2'd2 - bsel_q], (bsel_q == 2'd0) ? '0 : t_q);
						inv_q <= 31'd1;
						invb_q <= redm(c_q[bsel_q]);
						e_q <= '0;
						k_q <= {1'b0, exp_m2[0]};
						st_q <= S_INV;
					end
				end
				S_DONE: begin
					done <= 1'b1;
					result.newest_word <= sv_q[0];
					result.middle_word <= sv_q[1];
					result.oldest_word <= sv_q[2];
					e_q <= '0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
			// final multiply entry marks inverse complete
			if (st_q == S_INV_ACC && !k_q[0] && e_q == 5'd30) e_q <= 5'd31;
		end
	end
endmodule
